[sv/drift_time_to_radius_polynomial_unit_macros.svh]
// assertion macros for the drift time to radius unit
// used by the port checker, no other dependencies
`ifndef DRIFT_TIME_TO_RADIUS_POLYNOMIAL_UNIT_MACROS_SVH
`define DRIFT_TIME_TO_RADIUS_POLYNOMIAL_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DTR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DTR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dtr_pkg.sv]
// shared constants for the drift time to radius unit
// register indexes, field widths and reset values; no dependencies
`timescale 1ns / 1ps

package dtr_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_TIME_OFFSET     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_SPAN       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPAN_RECIPROCAL = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COEFF_PAIR_LOW  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COEFF_PAIR_2ND  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COEFF_PAIR_3RD  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_COEFF_PAIR_HIGH = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS_LIMIT    = 3'd7;

    // parameter defaults
    localparam int POLY_DEGREE_DEFAULT = 7;
    localparam int TIME_WIDTH_DEFAULT  = 20;
    localparam int MAX_COEFFS          = 8;

    // field widths
    localparam int OFFSET_W = 20;
    localparam int SPAN_W   = 20;
    localparam int RECIP_W  = 32;
    localparam int COEFF_W  = 32;
    localparam int RADIUS_W = 23;
    localparam int U_W      = 25;
    localparam int FRAC_W   = 24;
    localparam int U_SHIFT  = 8;

    // result channel packing
    localparam int M_DATA_W = ((RADIUS_W + 7) / 8) * 8;
    localparam int M_USER_W = 3;
    localparam int USER_BEFORE_BIT  = 0;
    localparam int USER_BEYOND_BIT  = 1;
    localparam int USER_CLAMPED_BIT = 2;

    // register reset values
    localparam logic [OFFSET_W-1:0] TIME_OFFSET_RESET     = 20'd0;
    localparam logic [SPAN_W-1:0]   TIME_SPAN_RESET       = 20'd1048575;
    localparam logic [RECIP_W-1:0]  SPAN_RECIPROCAL_RESET = 32'd4096;
    localparam logic [RADIUS_W-1:0] RADIUS_LIMIT_RESET    = 23'd5295309;

endpackage

[sv/drift_time_to_radius_polynomial_unit.sv]
// drift time to drift radius converter, degree-n horner polynomial pipeline
// depends on dtr_pkg
`timescale 1ns / 1ps

//  channel   ports          direction   payload
//  s_        tdata          in          drift_time
//  m_        tdata/tuser    out         radius; before_start, beyond_end, radius_clamped
//  cfg_      we/addr        in          register write, 8 registers
//
//  one item per cycle while the output is not stalled; the stages are: offset
//  subtract, span multiply, saturate, then a multiply stage and an add stage per
//  horner step, and the output register
//  aresetn is synchronous and clears the valid bits, the skid stage and the
//  registers to their reset values
//  a stall on m_tready freezes the whole pipeline; one input item is caught in a
//  skid stage, so s_tready is a register and only drops after a stall

module drift_time_to_radius_polynomial_unit #(
    parameter int POLY_DEGREE = dtr_pkg::POLY_DEGREE_DEFAULT,
    parameter int TIME_WIDTH  = dtr_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [dtr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dtr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((TIME_WIDTH+7)/8)*8-1:0] s_tdata,   // drift_time
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dtr_pkg::M_DATA_W-1:0]    m_tdata,   // radius
    output logic [dtr_pkg::M_USER_W-1:0]    m_tuser    // before_start, beyond_end,
                                                       // radius_clamped
);

    import dtr_pkg::*;

    localparam int CMP_W  = (TIME_WIDTH > SPAN_W) ? TIME_WIDTH : SPAN_W;
    localparam int PROD_W = COEFF_W + U_W + 1;       // signed acc times unsigned u
    localparam int SHR_W  = PROD_W - FRAC_W;         // product after the q24 shift
    localparam int SUM_W  = SHR_W + 1;
    localparam int NORM_W = SPAN_W + RECIP_W;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [OFFSET_W-1:0]   time_offset_reg;
    logic [SPAN_W-1:0]     time_span_reg;
    logic [RECIP_W-1:0]    span_recip_reg;
    logic [CFG_DATA_W-1:0] coeff_pair_reg [MAX_COEFFS/2];
    logic [RADIUS_W-1:0]   radius_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_offset_reg  <= TIME_OFFSET_RESET;
            time_span_reg    <= TIME_SPAN_RESET;
            span_recip_reg   <= SPAN_RECIPROCAL_RESET;
            radius_limit_reg <= RADIUS_LIMIT_RESET;
            for (int i = 0; i < MAX_COEFFS / 2; i++) begin
                coeff_pair_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_TIME_OFFSET:     time_offset_reg   <= cfg_wdata[OFFSET_W-1:0];
                REG_TIME_SPAN:       time_span_reg     <= cfg_wdata[SPAN_W-1:0];
                REG_SPAN_RECIPROCAL: span_recip_reg    <= cfg_wdata[RECIP_W-1:0];
                REG_COEFF_PAIR_LOW:  coeff_pair_reg[0] <= cfg_wdata;
                REG_COEFF_PAIR_2ND:  coeff_pair_reg[1] <= cfg_wdata;
                REG_COEFF_PAIR_3RD:  coeff_pair_reg[2] <= cfg_wdata;
                REG_COEFF_PAIR_HIGH: coeff_pair_reg[3] <= cfg_wdata;
                REG_RADIUS_LIMIT:    radius_limit_reg  <= cfg_wdata[RADIUS_W-1:0];
            endcase
        end
    end

    // coefficient k sits in pair k/2, low word for even k
    logic signed [COEFF_W-1:0] coeff [MAX_COEFFS];

    always_comb begin
        for (int i = 0; i < MAX_COEFFS / 2; i++) begin
            coeff[2*i]   = $signed(coeff_pair_reg[i][COEFF_W-1:0]);
            coeff[2*i+1] = $signed(coeff_pair_reg[i][2*COEFF_W-1:COEFF_W]);
        end
    end

    // ---------------------------------------------------------------
    // flow control: the whole pipeline moves when the output is free
    // ---------------------------------------------------------------
    logic pipe_en;
    assign pipe_en = !m_tvalid || m_tready;

    // skid stage catches one item while the pipeline is frozen
    logic                  skid_valid_reg;
    logic [TIME_WIDTH-1:0] skid_time_reg;

    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && s_tvalid && s_tready) begin
            skid_time_reg <= s_tdata[TIME_WIDTH-1:0];
        end
    end

    logic                  ent_valid;
    logic [TIME_WIDTH-1:0] ent_time;

    assign ent_valid = skid_valid_reg || s_tvalid;
    assign ent_time  = skid_valid_reg ? skid_time_reg : s_tdata[TIME_WIDTH-1:0];

    // ---------------------------------------------------------------
    // stage 1: subtract the offset, flag early items, clamp to the span
    // ---------------------------------------------------------------
    logic [TIME_WIDTH:0]   diff;
    logic [CMP_W-1:0]      diff_ext;
    logic [CMP_W-1:0]      span_ext;
    logic                  early;
    logic                  late;

    assign diff     = {1'b0, ent_time} - {1'b0, TIME_WIDTH'(time_offset_reg)};
    assign early    = diff[TIME_WIDTH];
    assign diff_ext = CMP_W'(diff[TIME_WIDTH-1:0]);
    assign span_ext = CMP_W'(time_span_reg);
    assign late     = !early && (diff_ext > span_ext);

    logic              st1_valid_reg;
    logic              st1_before_reg;
    logic              st1_beyond_reg;
    logic [SPAN_W-1:0] st1_delta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            st1_valid_reg <= ent_valid;
        end
    end

    // not late means the difference fits in the span width
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            st1_before_reg <= early;
            st1_beyond_reg <= late;
            st1_delta_reg  <= late ? time_span_reg : SPAN_W'(diff_ext);
        end
    end

    // ---------------------------------------------------------------
    // stage 2: normalize by the span reciprocal
    // ---------------------------------------------------------------
    logic              st2_valid_reg;
    logic              st2_before_reg;
    logic              st2_beyond_reg;
    logic [NORM_W-1:0] st2_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            st2_before_reg <= st1_before_reg;
            st2_beyond_reg <= st1_beyond_reg;
            st2_prod_reg   <= NORM_W'(st1_delta_reg) * NORM_W'(span_recip_reg);
        end
    end

    // ---------------------------------------------------------------
    // stage 3: u in q1.24, saturated; horner starts at the top coefficient
    // ---------------------------------------------------------------
    logic           u_over;
    logic [U_W-1:0] u_sat;

    assign u_over = |st2_prod_reg[NORM_W-1:U_SHIFT+U_W];
    assign u_sat  = u_over ? {U_W{1'b1}} : st2_prod_reg[U_SHIFT+U_W-1:U_SHIFT];

    logic                      st3_valid_reg;
    logic                      st3_before_reg;
    logic                      st3_beyond_reg;
    logic [U_W-1:0]            st3_u_reg;
    logic signed [COEFF_W-1:0] st3_acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            st3_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            st3_before_reg <= st2_before_reg;
            st3_beyond_reg <= st2_beyond_reg;
            st3_u_reg      <= u_sat;
            st3_acc_reg    <= coeff[POLY_DEGREE];
        end
    end

    // ---------------------------------------------------------------
    // horner steps: step j multiplies by u, then adds coefficient
    // POLY_DEGREE-1-j, floors the q24 product and saturates to 32 bits
    // ---------------------------------------------------------------
    logic                      mul_valid_reg  [POLY_DEGREE];
    logic                      mul_before_reg [POLY_DEGREE];
    logic                      mul_beyond_reg [POLY_DEGREE];
    logic [U_W-1:0]            mul_u_reg      [POLY_DEGREE];
    logic signed [PROD_W-1:0]  mul_prod_reg   [POLY_DEGREE];

    logic                      add_valid_reg  [POLY_DEGREE];
    logic                      add_before_reg [POLY_DEGREE];
    logic                      add_beyond_reg [POLY_DEGREE];
    logic [U_W-1:0]            add_u_reg      [POLY_DEGREE];
    logic signed [COEFF_W-1:0] add_acc_reg    [POLY_DEGREE];

    for (genvar j = 0; j < POLY_DEGREE; j++) begin : g_horner
        logic                      src_valid;
        logic                      src_before;
        logic                      src_beyond;
        logic [U_W-1:0]            src_u;
        logic signed [COEFF_W-1:0] src_acc;
        logic signed [SHR_W-1:0]   prod_shr;
        logic signed [SUM_W-1:0]   sum;
        logic                      sat_hi;
        logic                      sat_lo;
        logic signed [COEFF_W-1:0] acc_next;

        if (j == 0) begin : g_first
            assign src_valid  = st3_valid_reg;
            assign src_before = st3_before_reg;
            assign src_beyond = st3_beyond_reg;
            assign src_u      = st3_u_reg;
            assign src_acc    = st3_acc_reg;
        end else begin : g_chain
            assign src_valid  = add_valid_reg[j-1];
            assign src_before = add_before_reg[j-1];
            assign src_beyond = add_beyond_reg[j-1];
            assign src_u      = add_u_reg[j-1];
            assign src_acc    = add_acc_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mul_valid_reg[j] <= 1'b0;
            end else if (pipe_en) begin
                mul_valid_reg[j] <= src_valid;
            end
        end

        // both operands widened first so the full signed product is kept
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                mul_before_reg[j] <= src_before;
                mul_beyond_reg[j] <= src_beyond;
                mul_u_reg[j]      <= src_u;
                mul_prod_reg[j]   <= PROD_W'(src_acc) * PROD_W'($signed({1'b0, src_u}));
            end
        end

        // arithmetic shift is floor division by 2^24
        assign prod_shr = mul_prod_reg[j][PROD_W-1:FRAC_W];
        assign sum      = $signed({prod_shr[SHR_W-1], prod_shr})
                        + SUM_W'(coeff[POLY_DEGREE-1-j]);
        assign sat_hi   = !sum[SUM_W-1] && (|sum[SUM_W-2:COEFF_W-1]);
        assign sat_lo   = sum[SUM_W-1] && !(&sum[SUM_W-2:COEFF_W-1]);

        always_comb begin
            priority if (sat_hi) begin
                acc_next = {1'b0, {(COEFF_W-1){1'b1}}};
            end else if (sat_lo) begin
                acc_next = {1'b1, {(COEFF_W-1){1'b0}}};
            end else begin
                acc_next = sum[COEFF_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                add_valid_reg[j] <= 1'b0;
            end else if (pipe_en) begin
                add_valid_reg[j] <= mul_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                add_before_reg[j] <= mul_before_reg[j];
                add_beyond_reg[j] <= mul_beyond_reg[j];
                add_u_reg[j]      <= mul_u_reg[j];
                add_acc_reg[j]    <= acc_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // output register: clamp radius to zero .. radius_limit
    // ---------------------------------------------------------------
    logic signed [COEFF_W-1:0] fin_acc;
    logic                      fin_before;
    logic                      fin_neg;
    logic                      fin_over;
    logic [RADIUS_W-1:0]       radius_next;
    logic                      clamped_next;

    assign fin_acc    = add_acc_reg[POLY_DEGREE-1];
    assign fin_before = add_before_reg[POLY_DEGREE-1];
    assign fin_neg    = fin_acc[COEFF_W-1];
    assign fin_over   = !fin_neg
                     && (fin_acc[COEFF_W-2:0] > (COEFF_W-1)'(radius_limit_reg));

    // early items ignore the polynomial result: zero radius, no clamp flag
    always_comb begin
        priority if (fin_before) begin
            radius_next  = '0;
            clamped_next = 1'b0;
        end else if (fin_neg) begin
            radius_next  = '0;
            clamped_next = 1'b1;
        end else if (fin_over) begin
            radius_next  = radius_limit_reg;
            clamped_next = 1'b1;
        end else begin
            radius_next  = fin_acc[RADIUS_W-1:0];
            clamped_next = 1'b0;
        end
    end

    logic                out_valid_reg;
    logic [RADIUS_W-1:0] out_radius_reg;
    logic                out_before_reg;
    logic                out_beyond_reg;
    logic                out_clamped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= add_valid_reg[POLY_DEGREE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_radius_reg  <= radius_next;
            out_before_reg  <= fin_before;
            out_beyond_reg  <= add_beyond_reg[POLY_DEGREE-1];
            out_clamped_reg <= clamped_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_radius_reg);

    always_comb begin
        m_tuser                   = '0;
        m_tuser[USER_BEFORE_BIT]  = out_before_reg;
        m_tuser[USER_BEYOND_BIT]  = out_beyond_reg;
        m_tuser[USER_CLAMPED_BIT] = out_clamped_reg;
    end

endmodule

[sv/dtr_port_checker.sv]
// port-level checks for the drift time to radius unit, with its bind
// depends on dtr_pkg and drift_time_to_radius_polynomial_unit_macros.svh
`timescale 1ns / 1ps

`include "drift_time_to_radius_polynomial_unit_macros.svh"

module dtr_port_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dtr_pkg::M_DATA_W-1:0] m_tdata,   // radius
    input logic [dtr_pkg::M_USER_W-1:0] m_tuser    // before_start, beyond_end,
                                                   // radius_clamped
);

    import dtr_pkg::*;

    // a stalled result holds its payload
    `DTR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result item changed")

    // an early item carries zero radius and no other flag
    `DTR_ASSERT_SAME(a_early_item, aclk, aresetn, m_tvalid && m_tuser[USER_BEFORE_BIT],
        (m_tdata == '0) && !m_tuser[USER_BEYOND_BIT] && !m_tuser[USER_CLAMPED_BIT],
        "early item with nonzero radius or flags")

    // input back-pressure only follows an output stall
    `DTR_ASSERT_SAME(a_ready_after_stall, aclk, aresetn, !s_tready,
        $past(m_tvalid && !m_tready), "s_tready low without a preceding output stall")

endmodule

bind drift_time_to_radius_polynomial_unit dtr_port_checker u_dtr_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
